>>> rtl/core/mdp_pkg.sv
package mdp_pkg;

    // Field widths
    localparam int IDX_W = 11;
    localparam int H_W   = 21;
    localparam int RF_W  = 16;
    localparam int DEP_W = 4;

    // Height limits, unsigned Q5.16
    localparam logic [H_W-1:0] HEIGHT_MAX = 21'd1310720;
    localparam logic [H_W-1:0] HALF_RANGE = 21'd655360;

    // One segment: left index, depth in the tree, endpoint heights.
    // The right index follows from the left index and the depth.
    typedef struct packed {
        logic [IDX_W-1:0] from_idx;
        logic [DEP_W-1:0] depth;
        logic [H_W-1:0]   h_from;
        logic [H_W-1:0]   h_to;
    } t_seg;

    // Stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        t_seg data;
    } t_stk_cmd;

    // Stack status back to the sequencer
    typedef struct packed {
        logic empty;
        t_seg top;
    } t_stk_stat;

endpackage

>>> rtl/core/mdp_if.sv
// Input channel: one random fraction per word
interface mdp_in_if;
    logic                       valid;
    logic                       ready;
    logic [mdp_pkg::RF_W-1:0]   rand_fraction;

    modport source (output valid, output rand_fraction, input ready);
    modport sink   (input valid, input rand_fraction, output ready);
endinterface

// Output channel: one profile point per word
interface mdp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mdp_pkg::IDX_W-1:0]  point_index;
    logic [mdp_pkg::H_W-1:0]    height;
    logic                       last;

    modport source (output valid, output point_index, output height, output last, input ready);
    modport sink   (input valid, input point_index, input height, input last, output ready);
endinterface

>>> rtl/core/mdp_stack.sv
// Segment stack: top entry in a register, deeper entries in a memory.
// The memory read address follows the next count, so the entry under
// the top is always ready in the next cycle; a same-cycle write to that
// address is forwarded.
module mdp_stack #(
    parameter int DEPTH = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mdp_pkg::t_stk_cmd    i_cmd,
    output mdp_pkg::t_stk_stat   o_stat
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int MEMD = (DEPTH > 1) ? DEPTH - 1 : 1;
    localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;

    logic [CW-1:0]     r_cnt, n_cnt;
    mdp_pkg::t_seg     r_top, n_top;
    mdp_pkg::t_seg     r_mem [MEMD];
    mdp_pkg::t_seg     r_rdata;
    logic              r_fwd;
    mdp_pkg::t_seg     r_fwd_data;
    mdp_pkg::t_seg     below;
    logic              do_push, do_pop, wr_en, rd_en;
    logic [CW-1:0]     wr_diff, rd_diff;
    logic [AW-1:0]     wr_addr, rd_addr;

    // push is dropped on a full stack, pop on an empty one
    assign do_push = i_cmd.push && (r_cnt < CW'(DEPTH));
    assign do_pop  = i_cmd.pop && (r_cnt != '0);
    assign wr_en   = do_push && (r_cnt != '0);

    assign wr_diff = r_cnt - CW'(1);
    assign wr_addr = wr_diff[AW-1:0];
    assign rd_diff = n_cnt - CW'(2);
    assign rd_addr = rd_diff[AW-1:0];
    assign rd_en   = ({1'b0, n_cnt} >= (CW + 1)'(2));

    assign below = r_fwd ? r_fwd_data : r_rdata;

    // next count and top
    always_comb begin
        n_cnt = r_cnt;
        n_top = r_top;
        if (do_push) begin
            n_cnt = r_cnt + CW'(1);
            n_top = i_cmd.data;
        end else if (do_pop) begin
            n_cnt = r_cnt - CW'(1);
            n_top = below;
        end
    end

    // count, top and bypass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fwd <= wr_en && rd_en && (rd_addr == wr_addr);
        end
        r_top      <= n_top;
        r_fwd_data <= r_top;
    end

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.top   = r_top;

endmodule

>>> rtl/core/mdp_point.sv
// Midpoint of the current segment and its displaced height.
module mdp_point #(
    parameter int LEVELS = 10
) (
    input  logic [mdp_pkg::RF_W-1:0]   i_rand_fraction,
    input  mdp_pkg::t_seg              i_seg,
    output logic [mdp_pkg::H_W-1:0]    o_offset,
    output logic [mdp_pkg::IDX_W-1:0]  o_mid_idx,
    output logic [mdp_pkg::H_W-1:0]    o_height
);

    localparam int HW = mdp_pkg::H_W;
    localparam int SW = mdp_pkg::H_W + 2;
    localparam logic [mdp_pkg::IDX_W-1:0] FULL = mdp_pkg::IDX_W'(1 << LEVELS);
    localparam logic signed [SW-1:0] S_ZERO = '0;
    localparam logic signed [SW-1:0] S_MAX  = {2'b00, mdp_pkg::HEIGHT_MAX};

    logic [mdp_pkg::DEP_W:0]  half_sh;
    logic [HW-1:0]            offset, sh_off, sh_half, avg;
    logic [HW:0]              h_sum;
    logic signed [SW-1:0]     disp, h_up, h_dn, h_sel;
    logic                     up_ok;

    // midpoint index: left end plus half the span
    assign half_sh   = {1'b0, i_seg.depth} + (mdp_pkg::DEP_W + 1)'(1);
    assign o_mid_idx = i_seg.from_idx + (FULL >> half_sh);

    // 20*r as 16*r + 4*r
    assign offset   = HW'({i_rand_fraction, 4'b0000}) + HW'({i_rand_fraction, 2'b00});
    assign o_offset = offset;

    // displacement scaled by 2^-depth
    assign sh_off  = offset >> i_seg.depth;
    assign sh_half = mdp_pkg::HALF_RANGE >> i_seg.depth;
    assign disp    = $signed({2'b00, sh_off}) - $signed({2'b00, sh_half});

    // endpoint average, rounded down
    assign h_sum = {1'b0, i_seg.h_from} + {1'b0, i_seg.h_to};
    assign avg   = h_sum[HW:1];

    // displace up, or the other way when that leaves the open range
    assign h_up  = $signed({2'b00, avg}) + disp;
    assign h_dn  = $signed({2'b00, avg}) - disp;
    assign up_ok = (h_up > S_ZERO) && (h_up < S_MAX);
    assign h_sel = up_ok ? h_up : h_dn;

    // saturate
    always_comb begin
        if (h_sel < S_ZERO) begin
            o_height = '0;
        end else if (h_sel > S_MAX) begin
            o_height = mdp_pkg::HEIGHT_MAX;
        end else begin
            o_height = h_sel[HW-1:0];
        end
    end

endmodule

>>> rtl/core/midpoint_displacement_1d_unit.sv
// One-dimensional midpoint-displacement profile of 2^LEVELS+1 points. Every
// input word (one random fraction) yields exactly one output word: the first
// two give the heights of point 0 and point 2^LEVELS, each later one the next
// midpoint in depth-first order, left half first, with last set on the final
// point, after which the next word starts a new profile. One item is accepted
// every cycle while the output is taken; the rate is set by the loop from the
// current segment register through the combinational height datapath to the
// next segment, with the pending right halves kept in a stack whose top sits
// in a register and whose lower LEVELS-1 entries sit in a memory read ahead
// from the next count. The stack memory needs no clearing after reset.
module midpoint_displacement_1d_unit #(
    parameter int LEVELS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mdp_in_if.sink            i_in,
    mdp_out_if.source         o_out
);

    localparam logic [mdp_pkg::IDX_W-1:0] FULL = mdp_pkg::IDX_W'(1 << LEVELS);
    localparam logic [mdp_pkg::DEP_W-1:0] LEAF_DEPTH = mdp_pkg::DEP_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        ST_LEFT  = 3'b001,
        ST_RIGHT = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    mdp_pkg::t_seg               r_seg, n_seg;
    logic                        r_out_valid;
    logic [mdp_pkg::IDX_W-1:0]   r_out_idx, n_out_idx;
    logic [mdp_pkg::H_W-1:0]     r_out_h, n_out_h;
    logic                        r_out_last, n_out_last;

    logic                        acc;
    logic                        split;
    logic [mdp_pkg::H_W-1:0]     offset, mid_h;
    logic [mdp_pkg::IDX_W-1:0]   mid_idx;
    mdp_pkg::t_stk_cmd           stk_cmd;
    mdp_pkg::t_stk_stat          stk_stat;

    // handshake: take a word whenever the output register frees up
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;

    mdp_point #(
        .LEVELS (LEVELS)
    ) u_point (
        .i_rand_fraction (i_in.rand_fraction),
        .i_seg           (r_seg),
        .o_offset        (offset),
        .o_mid_idx       (mid_idx),
        .o_height        (mid_h)
    );

    mdp_stack #(
        .DEPTH (LEVELS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_stat  (stk_stat)
    );

    // segments wider than two steps get split further
    assign split = (r_seg.depth < LEAF_DEPTH);

    // sequencer: next segment, stack command, result word
    always_comb begin
        n_state      = r_state;
        n_seg        = r_seg;
        n_out_idx    = mid_idx;
        n_out_h      = mid_h;
        n_out_last   = 1'b0;
        stk_cmd.push = 1'b0;
        stk_cmd.pop  = 1'b0;
        stk_cmd.data = '{from_idx: mid_idx, depth: r_seg.depth + mdp_pkg::DEP_W'(1),
                         h_from: mid_h, h_to: r_seg.h_to};
        case (r_state)
            ST_LEFT: begin
                n_out_idx = '0;
                n_out_h   = offset;
                n_seg     = '{from_idx: '0, depth: '0, h_from: offset, h_to: '0};
                n_state   = ST_RIGHT;
            end
            ST_RIGHT: begin
                n_out_idx = FULL;
                n_out_h   = offset;
                n_seg     = '{from_idx: '0, depth: '0, h_from: r_seg.h_from, h_to: offset};
                n_state   = ST_RUN;
            end
            ST_RUN: begin
                if (split) begin
                    stk_cmd.push = acc;
                    n_seg = '{from_idx: r_seg.from_idx,
                              depth: r_seg.depth + mdp_pkg::DEP_W'(1),
                              h_from: r_seg.h_from, h_to: mid_h};
                end else if (!stk_stat.empty) begin
                    stk_cmd.pop = acc;
                    n_seg       = stk_stat.top;
                end else begin
                    n_out_last = 1'b1;
                    n_state    = ST_LEFT;
                end
            end
            default: begin
                n_state = ST_LEFT;
            end
        endcase
    end

    // sequencer state and current segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEFT;
        end else if (acc) begin
            r_state <= n_state;
        end
        if (acc) begin
            r_seg <= n_seg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (acc) begin
            r_out_idx  <= n_out_idx;
            r_out_h    <= n_out_h;
            r_out_last <= n_out_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_index = r_out_idx;
    assign o_out.height      = r_out_h;
    assign o_out.last        = r_out_last;

    // a pop is only issued with something on the stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_cmd.pop |-> !stk_stat.empty)
        else $error("stack pop while empty");

    // the final point of a profile is always the one just left of the end
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_idx == FULL - mdp_pkg::IDX_W'(1)))
        else $error("last flag on wrong point");

    // heights stay within range
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_h <= mdp_pkg::HEIGHT_MAX))
        else $error("height out of range");

    // after the last point the next word restarts at the left end
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_state == ST_RUN && n_out_last) |=> (r_state == ST_LEFT))
        else $error("profile did not restart");

endmodule
